/* rtl/pvf_pkg.sv */
// Package for the prism volume core: field widths, datapath widths,
// the control word of the shared multiply-accumulate unit, divider constants.
// No dependencies.
package pvf_pkg;

   // Transfer fields
   localparam int CornerW = 2;
   localparam int CoordW  = 18;
   localparam int VolW    = 63;

   // Corner codes
   localparam logic [CornerW-1:0] CornerZero = 2'd0;
   localparam logic [CornerW-1:0] CornerOne  = 2'd1;
   localparam logic [CornerW-1:0] CornerLast = 2'd2;
   localparam logic [CornerW-1:0] CornerNone = 2'd3;

   // Datapath widths
   localparam int DiffW = CoordW + 1;  // difference of two coordinates
   localparam int SumW  = CoordW + 2;  // S1, D1, S2, D2
   localparam int S3W   = SumW + 2;    // 3 * S1
   localparam int HW    = CoordW + 3;  // height vector H
   localparam int OpW   = 25;          // multiplier operand
   localparam int ProdW = 2 * OpW;     // multiplier product
   localparam int TW    = 44;          // 3 (S1 x S2) + D1 x D2, one component
   localparam int TLoW  = 22;          // low slice of T taken unsigned
   localparam int THiW  = TW - TLoW;   // high slice of T, signed
   localparam int NumW  = 64;          // triple product numerator

   // Divide by 72 = divide by 8 (shift) then by 9 (one byte a step)
   localparam int DigitW    = 8;
   localparam int DivSteps  = NumW / DigitW;
   localparam int Rem9W     = 4;
   localparam int Div8W     = 3;
   localparam int StepW     = Rem9W + DigitW;          // partial remainder
   localparam int RecipW    = 13;
   localparam int RecipSh   = 16;
   localparam logic [RecipW-1:0] Recip9 = 13'd7282;    // ceil(2^16 / 9)
   localparam int Rem72W    = Rem9W + Div8W;
   localparam logic [Rem72W-1:0] RoundHalf = 7'd36;
   localparam int DivCntW   = 4;

   typedef logic signed [CoordW-1:0] coord_type;

   // Control word that travels with one product through the shared unit
   typedef struct packed {
      logic issue;     // a product is being formed this cycle
      logic load;      // start a new sum instead of adding
      logic to_num;    // add into the numerator, else into T
      logic negate;    // subtract the product
      logic shift_hi;  // product carries weight 2^TLoW
   } mac_ctl_type;

endpackage

/* rtl/pvf_ifs.sv */
// Valid/ready channel interfaces of the prism volume core.
// Depends on pvf_pkg.
interface pvf_req_if;
   logic                           valid;
   logic                           ready;
   logic [pvf_pkg::CornerW-1:0]    corner;
   logic signed [pvf_pkg::CoordW-1:0] white_x;
   logic signed [pvf_pkg::CoordW-1:0] white_y;
   logic signed [pvf_pkg::CoordW-1:0] white_z;
   logic signed [pvf_pkg::CoordW-1:0] gray_x;
   logic signed [pvf_pkg::CoordW-1:0] gray_y;
   logic signed [pvf_pkg::CoordW-1:0] gray_z;

   modport source (output valid, corner, white_x, white_y, white_z,
                   gray_x, gray_y, gray_z, input ready);
   modport sink   (input valid, corner, white_x, white_y, white_z,
                   gray_x, gray_y, gray_z, output ready);
endinterface

interface pvf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [pvf_pkg::VolW-1:0] volume;
   logic                            was_clamped;

   modport source (output valid, volume, was_clamped, input ready);
   modport sink   (input valid, volume, was_clamped, output ready);
endinterface

/* rtl/prism_volume_fixed_point_core.sv */
// Prism volume core, top level: corner store, sequencer around the shared
// multiply-accumulate unit, divide-by-72, result register and CSR port.
// Depends on pvf_pkg, pvf_ifs (pvf_req_if, pvf_rsp_if), pvf_mac, pvf_div72.
//
//   channel | direction | handshake           | carries
//   --------+-----------+---------------------+------------------------------------
//   req_ch  | in        | valid/ready         | corner, white_x..z, gray_x..z
//   rsp_ch  | out       | valid/ready         | volume, was_clamped
//   csr_*   | in/out    | APB, pready tied 1  | clamp_negative at byte address 0
//
// Corners 0, 1 and 3 leave the sequencer idle; ready stays high for them.
// After a corner-2 transfer ready stays low for these steps: three component passes
// on the shared multiplier, each over the slots S1, S2, D1, D2, Gap, Lo and Hi; a
// flush state; a divider start state; the divider byte steps and rounding step;
// and the load of the result register. The multiplier sets the pace.
// Reset is synchronous and clears the corner store, clamp register and control.
// A stalled result holds in the output register; a new corner-2 computation
// waits for it before it writes its own result.
module prism_volume_fixed_point_core (
   input  logic                  clock,
   input  logic                  reset,
   pvf_req_if.sink               req_ch,
   pvf_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import pvf_pkg::*;

   // Sequencer states
   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StMul   = 3'd1;
   localparam logic [2:0] StFlush = 3'd2;
   localparam logic [2:0] StStart = 3'd3;
   localparam logic [2:0] StWait  = 3'd4;

   // Slots within one component pass on the multiplier
   localparam logic [2:0] SlotS1  = 3'd0;  // +3S1[i] * S2[j]
   localparam logic [2:0] SlotS2  = 3'd1;  // -3S1[j] * S2[i]
   localparam logic [2:0] SlotD1  = 3'd2;  // +D1[i] * D2[j]
   localparam logic [2:0] SlotD2  = 3'd3;  // -D1[j] * D2[i]
   localparam logic [2:0] SlotGap = 3'd4;  // let T settle
   localparam logic [2:0] SlotLo  = 3'd5;  // +H[k] * T[low]
   localparam logic [2:0] SlotHi  = 3'd6;  // +H[k] * T[high] << TLoW

   localparam logic [1:0] LastComp = 2'd2;

   // CSR map
   localparam logic RegClamp = 1'b0;

   logic [2:0] state_ff, state_in;
   logic [2:0] slot_ff, slot_in;
   logic [1:0] comp_ff, comp_in;
   logic       clamp_ff, clamp_in;

   // Corner store: white and gray points of corners 0 and 1
   coord_type w_st_ff [2][3];
   coord_type g_st_ff [2][3];

   // Operand vectors; slot 0 is always the component being worked on
   logic signed [S3W-1:0]  s13_ff [3];
   logic signed [SumW-1:0] s2_ff  [3];
   logic signed [SumW-1:0] d1_ff  [3];
   logic signed [SumW-1:0] d2_ff  [3];
   logic signed [HW-1:0]   h_ff   [3];

   logic signed [VolW-1:0] vol_ff, vol_in;
   logic                   clmp_ff, clmp_in;
   logic                   rvalid_ff, rvalid_in;

   coord_type              wn [3];
   coord_type              gn [3];
   logic signed [S3W-1:0]  s13_new [3];
   logic signed [SumW-1:0] s2_new  [3];
   logic signed [SumW-1:0] d1_new  [3];
   logic signed [SumW-1:0] d2_new  [3];
   logic signed [HW-1:0]   h_new   [3];

   logic                   req_xfer;
   logic                   rsp_free;
   logic                   csr_wr;

   mac_ctl_type            mac_ctl;
   logic signed [OpW-1:0]  op_a;
   logic signed [OpW-1:0]  op_b;
   logic signed [TW-1:0]   t_acc;
   logic signed [NumW-1:0] num_acc;

   logic                   div_start;
   logic signed [VolW-1:0] div_vol;
   logic                   div_done;
   logic                   take_result;

   assign req_ch.ready = (state_ff == StIdle);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rvalid_ff || rsp_ch.ready;

   // ---------------------------------------------------------------------
   // CSR port: zero-wait writes, register 0 holds clamp_negative
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      clamp_in = clamp_ff;
      if (csr_wr && csr_paddr[2] == RegClamp) begin
         clamp_in = csr_pwdata[0];
      end
      csr_prdata = (csr_paddr[2] == RegClamp) ? {31'd0, clamp_ff} : 32'd0;
   end

   // ---------------------------------------------------------------------
   // Edge vectors of the wedge, formed in the transfer cycle of corner 2
   // ---------------------------------------------------------------------
   always_comb begin
      logic signed [DiffW-1:0] a_v, b_v, c_v, e_v;
      logic signed [SumW-1:0]  s1_v;
      logic signed [HW-1:0]    gsum, wsum;
      wn[0] = req_ch.white_x;
      wn[1] = req_ch.white_y;
      wn[2] = req_ch.white_z;
      gn[0] = req_ch.gray_x;
      gn[1] = req_ch.gray_y;
      gn[2] = req_ch.gray_z;
      for (int k = 0; k < 3; k++) begin
         a_v  = DiffW'(w_st_ff[1][k]) - DiffW'(w_st_ff[0][k]);
         b_v  = DiffW'(g_st_ff[1][k]) - DiffW'(g_st_ff[0][k]);
         c_v  = DiffW'(wn[k]) - DiffW'(w_st_ff[0][k]);
         e_v  = DiffW'(gn[k]) - DiffW'(g_st_ff[0][k]);
         s1_v = SumW'(a_v) + SumW'(b_v);
         s13_new[k] = S3W'(s1_v) + {s1_v[SumW-1], s1_v, 1'b0};
         d1_new[k]  = SumW'(b_v) - SumW'(a_v);
         s2_new[k]  = SumW'(c_v) + SumW'(e_v);
         d2_new[k]  = SumW'(e_v) - SumW'(c_v);
         gsum = HW'(g_st_ff[0][k]) + HW'(g_st_ff[1][k]) + HW'(gn[k]);
         wsum = HW'(w_st_ff[0][k]) + HW'(w_st_ff[1][k]) + HW'(wn[k]);
         h_new[k] = gsum - wsum;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: per component k (always in slot 0 after rotation),
   // T = 3 (S1 x S2)[k] + (D1 x D2)[k], then numerator += H[k] * T
   // ---------------------------------------------------------------------
   always_comb begin
      mac_ctl = '0;
      op_a    = '0;
      op_b    = '0;
      if (state_ff == StMul) begin
         unique case (slot_ff)
            SlotS1: begin
               mac_ctl.issue = 1'b1;
               mac_ctl.load  = 1'b1;
               op_a = OpW'(s13_ff[1]);
               op_b = OpW'(s2_ff[2]);
            end
            SlotS2: begin
               mac_ctl.issue  = 1'b1;
               mac_ctl.negate = 1'b1;
               op_a = OpW'(s13_ff[2]);
               op_b = OpW'(s2_ff[1]);
            end
            SlotD1: begin
               mac_ctl.issue = 1'b1;
               op_a = OpW'(d1_ff[1]);
               op_b = OpW'(d2_ff[2]);
            end
            SlotD2: begin
               mac_ctl.issue  = 1'b1;
               mac_ctl.negate = 1'b1;
               op_a = OpW'(d1_ff[2]);
               op_b = OpW'(d2_ff[1]);
            end
            SlotGap: begin
               mac_ctl = '0;
            end
            SlotLo: begin
               mac_ctl.issue  = 1'b1;
               mac_ctl.to_num = 1'b1;
               mac_ctl.load   = (comp_ff == 2'd0);
               op_a = OpW'(h_ff[0]);
               op_b = $signed({{(OpW-TLoW){1'b0}}, t_acc[TLoW-1:0]});
            end
            SlotHi: begin
               mac_ctl.issue    = 1'b1;
               mac_ctl.to_num   = 1'b1;
               mac_ctl.shift_hi = 1'b1;
               op_a = OpW'(h_ff[0]);
               op_b = OpW'($signed(t_acc[TW-1:TLoW]));
            end
            default: begin
               mac_ctl = '0;
            end
         endcase
      end
   end

   assign div_start   = (state_ff == StStart);
   assign take_result = (state_ff == StWait) && div_done && rsp_free;

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      comp_in  = comp_ff;
      unique case (state_ff)
         StIdle: begin
            if (req_xfer && req_ch.corner == CornerLast) begin
               state_in = StMul;
               slot_in  = SlotS1;
               comp_in  = '0;
            end
         end
         StMul: begin
            if (slot_ff == SlotHi) begin
               slot_in = SlotS1;
               comp_in = comp_ff + 2'd1;
               if (comp_ff == LastComp) begin
                  state_in = StFlush;
               end
            end else begin
               slot_in = slot_ff + 3'd1;
            end
         end
         StFlush: begin
            state_in = StStart;
         end
         StStart: begin
            state_in = StWait;
         end
         StWait: begin
            if (take_result) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Result register: hold until the transfer completes
   // ---------------------------------------------------------------------
   always_comb begin
      rvalid_in = rvalid_ff;
      vol_in    = vol_ff;
      clmp_in   = clmp_ff;
      if (rvalid_ff && rsp_ch.ready) begin
         rvalid_in = 1'b0;
      end
      if (take_result) begin
         // A rounded zero carries no sign bit, so it is never flagged
         rvalid_in = 1'b1;
         clmp_in   = clamp_ff && div_vol[VolW-1];
         vol_in    = (clamp_ff && div_vol[VolW-1]) ? '0 : div_vol;
      end
   end

   assign rsp_ch.valid       = rvalid_ff;
   assign rsp_ch.volume      = vol_ff;
   assign rsp_ch.was_clamped = clmp_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         slot_ff   <= SlotS1;
         comp_ff   <= '0;
         clamp_ff  <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         comp_ff   <= comp_in;
         clamp_ff  <= clamp_in;
         rvalid_ff <= rvalid_in;
      end
      vol_ff  <= vol_in;
      clmp_ff <= clmp_in;
   end

   // Corner store: written by corners 0 and 1, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) begin
               w_st_ff[i][k] <= '0;
               g_st_ff[i][k] <= '0;
            end
         end
      end else if (req_xfer &&
                   (req_ch.corner == CornerZero || req_ch.corner == CornerOne)) begin
         for (int k = 0; k < 3; k++) begin
            w_st_ff[req_ch.corner[0]][k] <= wn[k];
            g_st_ff[req_ch.corner[0]][k] <= gn[k];
         end
      end
   end

   // Operand vectors: load on corner 2, rotate after each component
   always_ff @(posedge clock) begin
      if (req_xfer && req_ch.corner == CornerLast) begin
         for (int k = 0; k < 3; k++) begin
            s13_ff[k] <= s13_new[k];
            s2_ff[k]  <= s2_new[k];
            d1_ff[k]  <= d1_new[k];
            d2_ff[k]  <= d2_new[k];
            h_ff[k]   <= h_new[k];
         end
      end else if (state_ff == StMul && slot_ff == SlotHi) begin
         for (int k = 0; k < 3; k++) begin
            s13_ff[k] <= s13_ff[(k + 1) % 3];
            s2_ff[k]  <= s2_ff[(k + 1) % 3];
            d1_ff[k]  <= d1_ff[(k + 1) % 3];
            d2_ff[k]  <= d2_ff[(k + 1) % 3];
            h_ff[k]   <= h_ff[(k + 1) % 3];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared arithmetic
   // ---------------------------------------------------------------------
   pvf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .op_a    (op_a),
      .op_b    (op_b),
      .t_acc   (t_acc),
      .num_acc (num_acc)
   );

   pvf_div72 u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_acc),
      .vol   (div_vol),
      .done  (div_done)
   );

endmodule

/* rtl/pvf_mac.sv */
// Shared multiply-accumulate unit: one registered signed multiplier feeding
// two accumulators (T component and triple-product numerator).
// Depends on pvf_pkg.
module pvf_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  pvf_pkg::mac_ctl_type              ctl,
   input  logic signed [pvf_pkg::OpW-1:0]    op_a,
   input  logic signed [pvf_pkg::OpW-1:0]    op_b,
   output logic signed [pvf_pkg::TW-1:0]     t_acc,
   output logic signed [pvf_pkg::NumW-1:0]   num_acc
);
   import pvf_pkg::*;

   logic signed [ProdW-1:0] prod_ff, prod_in;
   mac_ctl_type             pctl_ff, pctl_in;
   logic signed [TW-1:0]    t_ff, t_in;
   logic signed [NumW-1:0]  num_ff, num_in;
   logic signed [ProdW-1:0] addend;
   logic signed [NumW-1:0]  num_add;
   logic signed [NumW-1:0]  num_base;
   logic signed [TW-1:0]    t_base;

   always_comb begin
      prod_in = op_a * op_b;
      pctl_in = ctl;
   end

   always_comb begin
      addend   = pctl_ff.negate ? -prod_ff : prod_ff;
      num_add  = pctl_ff.shift_hi ? {addend[NumW-TLoW-1:0], {TLoW{1'b0}}}
                                  : NumW'(addend);
      t_base   = pctl_ff.load ? '0 : t_ff;
      num_base = pctl_ff.load ? '0 : num_ff;
      t_in     = t_ff;
      num_in   = num_ff;
      if (pctl_ff.issue && pctl_ff.to_num) begin
         num_in = num_base + num_add;
      end else if (pctl_ff.issue) begin
         t_in = t_base + $signed(addend[TW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pctl_ff <= '0;
      end else begin
         pctl_ff <= pctl_in;
      end
      prod_ff <= prod_in;
      t_ff    <= t_in;
      num_ff  <= num_in;
   end

   assign t_acc   = t_ff;
   assign num_acc = num_ff;

endmodule

/* rtl/pvf_div72.sv */
// Divide-by-72 sequencer: round to nearest (ties away from zero) of a signed
// 64-bit numerator, one byte of quotient per cycle, then a rounding step.
// Depends on pvf_pkg.
module pvf_div72 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [pvf_pkg::NumW-1:0]  num,
   output logic signed [pvf_pkg::VolW-1:0]  vol,
   output logic                             done
);
   import pvf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DivCntW-1:0]     cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [NumW-1:0]        dvd_ff, dvd_in;
   logic [Rem9W-1:0]       rem_ff, rem_in;
   logic [Div8W-1:0]       r3_ff, r3_in;
   logic signed [VolW-1:0] vol_ff, vol_in;

   logic [NumW-1:0]        mag;
   logic [StepW-1:0]       part;
   logic [StepW+RecipW-1:0] recip;
   logic [DigitW-1:0]      digit;
   logic [StepW-1:0]       back;
   logic [StepW-1:0]       left;
   logic [Rem72W-1:0]      rem72;
   logic                   inc;
   logic [VolW-1:0]        quo;

   always_comb begin
      mag   = num[NumW-1] ? (~num + NumW'(1)) : num;
      // Partial remainder below 9 * 256; reciprocal product is exact here
      part  = {rem_ff, dvd_ff[NumW-1 -: DigitW]};
      recip = part * Recip9;
      digit = recip[RecipSh +: DigitW];
      back  = {1'b0, digit, 3'b000} + StepW'(digit);
      left  = part - back;
      rem72 = {rem_ff, r3_ff};
      inc   = rem72 >= RoundHalf;
      quo   = dvd_ff[VolW-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      r3_in   = r3_ff;
      vol_in  = vol_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         neg_in  = num[NumW-1];
         dvd_in  = {{Div8W{1'b0}}, mag[NumW-1:Div8W]};
         r3_in   = mag[Div8W-1:0];
         rem_in  = '0;
      end else if (busy_ff && cnt_ff == DivCntW'(DivSteps)) begin
         // Round and apply the sign in one add: -(q+inc) = ~q + !inc
         busy_in = 1'b0;
         done_in = 1'b1;
         vol_in  = neg_ff ? $signed(~quo + VolW'(!inc)) : $signed(quo + VolW'(inc));
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DivCntW'(1);
         dvd_in = {dvd_ff[NumW-DigitW-1:0], digit};
         rem_in = left[Rem9W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      r3_ff  <= r3_in;
      vol_ff <= vol_in;
   end

   assign vol  = vol_ff;
   assign done = done_ff;

endmodule
